/* sv/swd_hte_pkg.sv */
//------------------------------------------------------------------------------
// SWD host transfer engine package
// Transaction payload types, phase codes, register indexes and helpers that
// the transfer engine and its checker share.
//------------------------------------------------------------------------------
package swd_hte_pkg;

	localparam int unsigned DataBits = 33;
	localparam int unsigned ReqBits  = 8;
	localparam int unsigned AckBits  = 3;
	localparam int unsigned BcW      = 6;

	localparam logic [2:0] AckOk    = 3'd1;
	localparam logic [2:0] AckWait  = 3'd2;
	localparam logic [2:0] AckFault = 3'd4;

	localparam logic [1:0] CfgTurnaround = 2'd0;
	localparam logic [1:0] CfgIdle       = 2'd1;
	localparam logic [1:0] CfgDataOnWait = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_REQ         = 4'd1,
		PH_TRN_ACK     = 4'd2,
		PH_ACK         = 4'd3,
		PH_RDATA       = 4'd4,
		PH_TRN_RD      = 4'd5,
		PH_TRN_WR      = 4'd6,
		PH_WDATA       = 4'd7,
		PH_IDLECYC     = 4'd8,
		PH_RELEASE_END = 4'd9,
		PH_TRN_WZ      = 4'd10,
		PH_WZERO       = 4'd11
	} phase_t;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  request_bits;
		logic [31:0] write_data;
		logic        line_sample;
	} swd_in_t;

	typedef struct packed {
		logic        line_out;
		logic        line_drive;
		logic        busy_res;
		logic        done_res;
		logic [2:0]  ack_code;
		logic        parity_error;
		logic [31:0] read_data;
	} swd_out_t;

	// Turnaround length clamped to the legal range of one to four periods.
	function automatic logic [BcW-1:0] trn_len(input logic [2:0] t);
		logic [BcW-1:0] r;
		if (t == 3'd0) begin
			r = BcW'(1);
		end else if (t > 3'd4) begin
			r = BcW'(4);
		end else begin
			r = BcW'(t);
		end
		return r;
	endfunction

endpackage

/* sv/swd_host_transfer_engine.sv */
//------------------------------------------------------------------------------
// SWD host transfer engine
// Steps one Serial Wire Debug transfer, one SWCLK period per tick transaction.
// The result of an accepted input transaction is registered and appears in the cycle after acceptance.
// Throughput is one transaction per cycle while results are taken; the phase update and the result
// register both update together, so no stall arises internally, only out_ready back-pressure.
// Input is accepted whenever the result register is empty or being taken.
// Reset clears the phase, counters, control state, config registers and result valid flag to defaults.
//------------------------------------------------------------------------------
module swd_host_transfer_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  swd_hte_pkg::swd_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output swd_hte_pkg::swd_out_t  out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [7:0]             cfg_data
);
	import swd_hte_pkg::*;

	logic [2:0]        trn_cfg_q;
	logic [7:0]        idle_cfg_q;
	logic              dpw_cfg_q;

	phase_t            phase_q, phase_d;
	logic [BcW-1:0]    bc_q, bc_d;
	logic [DataBits-1:0] shift_q, shift_d;
	logic [3:0]        req_q, req_d;
	logic [2:0]        ack_q, ack_d;
	logic              pacc_q, pacc_d;
	logic [7:0]        ic_q, ic_d;

	logic              out_valid_q;
	swd_out_t          out_data_q;
	swd_out_t          res;

	logic              in_fire;
	logic [BcW-1:0]    bc_inc;
	logic [BcW-1:0]    bc_dec;
	logic [ReqBits-1:0] hdr;
	logic              smp;
	logic              fin_ok;
	logic              xfer_end;
	logic              is_rd;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	assign bc_inc = bc_q + BcW'(1);
	assign bc_dec = bc_q - BcW'(1);
	assign hdr    = {1'b1, 1'b0, ^req_q, req_q, 1'b1};
	assign smp    = in_data.line_sample;
	assign is_rd  = req_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trn_cfg_q  <= 3'd1;
			idle_cfg_q <= 8'd0;
			dpw_cfg_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CfgTurnaround: trn_cfg_q  <= cfg_data[2:0];
				CfgIdle:       idle_cfg_q <= cfg_data;
				CfgDataOnWait: dpw_cfg_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		phase_d  = phase_q;
		bc_d     = bc_q;
		shift_d  = shift_q;
		req_d    = req_q;
		ack_d    = ack_q;
		pacc_d   = pacc_q;
		ic_d     = ic_q;
		fin_ok   = 1'b0;
		xfer_end = 1'b0;
		res      = '0;
		res.line_out   = 1'b1;
		res.line_drive = 1'b1;

		if (!in_data.cmd) begin
			if (phase_q == PH_IDLE) begin
				req_d   = in_data.request_bits;
				shift_d = {^in_data.write_data, in_data.write_data};
				ack_d   = '0;
				pacc_d  = 1'b0;
				bc_d    = '0;
				phase_d = PH_REQ;
			end
			res.busy_res = 1'b1;
		end else if (phase_q != PH_IDLE) begin
			res.busy_res = 1'b1;
			unique case (phase_q)
				PH_REQ: begin
					res.line_out = hdr[bc_q[2:0]];
					bc_d = bc_inc;
					if (bc_inc >= BcW'(ReqBits)) begin
						bc_d    = trn_len(trn_cfg_q);
						phase_d = PH_TRN_ACK;
					end
				end
				PH_TRN_ACK: begin
					res.line_drive = 1'b0;
					bc_d = bc_dec;
					if (bc_dec == '0) begin
						phase_d = PH_ACK;
					end
				end
				PH_ACK: begin
					res.line_drive = 1'b0;
					ack_d = ack_q | (3'(smp) << bc_q[1:0]);
					bc_d  = bc_inc;
					if (bc_inc >= BcW'(AckBits)) begin
						if (ack_d == AckOk) begin
							if (is_rd) begin
								bc_d    = '0;
								pacc_d  = 1'b0;
								phase_d = PH_RDATA;
							end else begin
								bc_d    = trn_len(trn_cfg_q);
								phase_d = PH_TRN_WR;
							end
						end else if (ack_d == AckWait || ack_d == AckFault) begin
							if (dpw_cfg_q && !is_rd) begin
								bc_d    = trn_len(trn_cfg_q);
								phase_d = PH_TRN_WZ;
							end else begin
								bc_d = trn_len(trn_cfg_q) +
									(dpw_cfg_q ? BcW'(DataBits) : '0);
								phase_d = PH_RELEASE_END;
							end
						end else begin
							bc_d    = trn_len(trn_cfg_q) + BcW'(DataBits);
							phase_d = PH_RELEASE_END;
						end
					end
				end
				PH_RDATA: begin
					res.line_drive = 1'b0;
					if (bc_q < BcW'(DataBits)) begin
						shift_d[bc_q] = smp;
					end
					pacc_d = pacc_q ^ smp;
					bc_d   = bc_inc;
					if (bc_inc >= BcW'(DataBits)) begin
						bc_d    = trn_len(trn_cfg_q);
						phase_d = PH_TRN_RD;
					end
				end
				PH_TRN_RD: begin
					res.line_drive = 1'b0;
					bc_d = bc_dec;
					if (bc_dec == '0) begin
						fin_ok = 1'b1;
					end
				end
				PH_TRN_WR: begin
					res.line_drive = 1'b0;
					bc_d = bc_dec;
					if (bc_dec == '0) begin
						phase_d = PH_WDATA;
					end
				end
				PH_WDATA: begin
					res.line_out = (bc_q < BcW'(DataBits)) ? shift_q[bc_q] : 1'b0;
					bc_d = bc_inc;
					if (bc_inc >= BcW'(DataBits)) begin
						fin_ok = 1'b1;
					end
				end
				PH_IDLECYC: begin
					res.line_out = 1'b0;
					if (ic_q != 8'd0) begin
						ic_d = ic_q - 8'd1;
					end
					if (ic_d == 8'd0) begin
						xfer_end = 1'b1;
					end
				end
				PH_RELEASE_END, PH_TRN_WZ: begin
					res.line_drive = 1'b0;
					bc_d = bc_dec;
					if (bc_dec == '0) begin
						if (phase_q == PH_TRN_WZ) begin
							phase_d = PH_WZERO;
						end else begin
							xfer_end = 1'b1;
						end
					end
				end
				PH_WZERO: begin
					res.line_out = 1'b0;
					bc_d = bc_inc;
					if (bc_inc >= BcW'(DataBits)) begin
						xfer_end = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					bc_d    = '0;
				end
			endcase

			if (fin_ok) begin
				ic_d = idle_cfg_q;
				if (idle_cfg_q == 8'd0) begin
					xfer_end = 1'b1;
				end else begin
					phase_d = PH_IDLECYC;
				end
			end

			if (xfer_end) begin
				res.done_res = 1'b1;
				if (ack_d == AckOk && is_rd) begin
					res.parity_error = pacc_d;
					res.read_data    = shift_d[31:0];
				end
				phase_d = PH_IDLE;
				bc_d    = '0;
			end
		end

		if (!res.line_drive) begin
			res.line_out = 1'b0;
		end
		res.ack_code = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bc_q    <= '0;
			shift_q <= '0;
			req_q   <= '0;
			ack_q   <= '0;
			pacc_q  <= 1'b0;
			ic_q    <= '0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			bc_q    <= bc_d;
			shift_q <= shift_d;
			req_q   <= req_d;
			ack_q   <= ack_d;
			pacc_q  <= pacc_d;
			ic_q    <= ic_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= res;
		end
	end

endmodule

/* sv/swd_hte_checker.sv */
//------------------------------------------------------------------------------
// SWD host transfer engine checker
// Watches the ports of the transfer engine and flags inconsistent results.
//------------------------------------------------------------------------------
module swd_hte_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input swd_hte_pkg::swd_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Stalled result transaction changed.");

	a_released_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.line_drive |-> !out_data.line_out)
		else $error("Released line reported as high.");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> out_data.busy_res)
		else $error("Done reported outside a transfer.");

	a_data_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |->
			out_data.read_data == '0 && !out_data.parity_error)
		else $error("Read data reported before the transfer ended.");

endmodule

bind swd_host_transfer_engine swd_hte_checker u_swd_hte_checker (.*);

/* test/swd_host_transfer_engine_tb.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// SWD host transfer engine testbench
// Drives start and tick transactions through the engine and compares every
// result, field by field, with an internal model of the transfer sequencer.
// The run walks several register settings and idling patterns, mixing
// well-formed transfers with random acks, data and stray transactions.
//------------------------------------------------------------------------------
module swd_host_transfer_engine_tb;
	import swd_hte_pkg::*;

	localparam int ClkPeriod   = 10;
	localparam int PhaseBudget = 180;
	localparam int QuietLimit  = 2000;
	localparam int HoldCycles  = 200;
	localparam int MaxReports  = 200;

	class swd_transfer_scoreboard;
		logic [2:0]  trn_reg;
		logic [7:0]  idle_reg;
		logic        dpw_reg;
		phase_t      ph;
		logic [5:0]  cnt;
		logic [32:0] shreg;
		logic [3:0]  req_q;
		logic [2:0]  ack_q;
		logic        par_q;
		logic [7:0]  idle_cnt;
		swd_out_t    pending_results[$];
		int          errors;
		int          n_items;
		int          n_done;
		int          n_read_ok;
		int          n_perr;

		function new();
			trn_reg = 3'd1;
			idle_reg = '0;
			dpw_reg = 1'b0;
			ph = PH_IDLE;
			cnt = '0;
			shreg = '0;
			req_q = '0;
			ack_q = '0;
			par_q = 1'b0;
			idle_cnt = '0;
			errors = 0;
			n_items = 0;
			n_done = 0;
			n_read_ok = 0;
			n_perr = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CfgTurnaround: trn_reg = val[2:0];
				CfgIdle:       idle_reg = val;
				CfgDataOnWait: dpw_reg = val[0];
				default: ;
			endcase
		endfunction

		function logic [5:0] trn_periods();
			logic [5:0] r;
			if (trn_reg == 3'd0) begin
				r = 6'd1;
			end else if (trn_reg > 3'd4) begin
				r = 6'd4;
			end else begin
				r = {3'd0, trn_reg};
			end
			return r;
		endfunction

		function logic enter_idle_or_end();
			idle_cnt = idle_reg;
			if (idle_cnt == 8'd0) begin
				return 1'b1;
			end
			ph = PH_IDLECYC;
			return 1'b0;
		endfunction

		function swd_out_t advance_engine(swd_in_t it);
			swd_out_t r;
			logic lo;
			logic drv;
			logic fin;
			logic rd;
			logic [7:0] hdr;
			r = '0;
			lo = 1'b1;
			drv = 1'b1;
			fin = 1'b0;
			if (!it.cmd) begin
				if (ph == PH_IDLE) begin
					req_q = it.request_bits;
					shreg = {^it.write_data, it.write_data};
					ack_q = '0;
					par_q = 1'b0;
					cnt = '0;
					ph = PH_REQ;
				end
				r.busy_res = (ph != PH_IDLE);
			end else if (ph != PH_IDLE) begin
				r.busy_res = 1'b1;
				rd = req_q[1];
				case (ph)
					PH_REQ: begin
						hdr = {1'b1, 1'b0, ^req_q, req_q, 1'b1};
						lo = hdr[cnt[2:0]];
						cnt++;
						if (cnt >= 6'd8) begin
							cnt = trn_periods();
							ph = PH_TRN_ACK;
						end
					end
					PH_TRN_ACK: begin
						drv = 1'b0;
						cnt--;
						if (cnt == 6'd0) ph = PH_ACK;
					end
					PH_ACK: begin
						drv = 1'b0;
						ack_q = ack_q | (3'(it.line_sample) << cnt[1:0]);
						cnt++;
						if (cnt >= 6'd3) begin
							if (ack_q == AckOk) begin
								if (rd) begin
									cnt = '0;
									par_q = 1'b0;
									ph = PH_RDATA;
								end else begin
									cnt = trn_periods();
									ph = PH_TRN_WR;
								end
							end else if (ack_q == AckWait || ack_q == AckFault) begin
								if (dpw_reg && !rd) begin
									cnt = trn_periods();
									ph = PH_TRN_WZ;
								end else begin
									cnt = trn_periods() + (dpw_reg ? 6'd33 : 6'd0);
									ph = PH_RELEASE_END;
								end
							end else begin
								cnt = trn_periods() + 6'd33;
								ph = PH_RELEASE_END;
							end
						end
					end
					PH_RDATA: begin
						drv = 1'b0;
						if (cnt < 6'd33) shreg[cnt] = it.line_sample;
						par_q = par_q ^ it.line_sample;
						cnt++;
						if (cnt >= 6'd33) begin
							cnt = trn_periods();
							ph = PH_TRN_RD;
						end
					end
					PH_TRN_RD: begin
						drv = 1'b0;
						cnt--;
						if (cnt == 6'd0) fin = enter_idle_or_end();
					end
					PH_TRN_WR: begin
						drv = 1'b0;
						cnt--;
						if (cnt == 6'd0) ph = PH_WDATA;
					end
					PH_WDATA: begin
						lo = (cnt >= 6'd32) ? shreg[32] : shreg[cnt[4:0]];
						cnt++;
						if (cnt >= 6'd33) fin = enter_idle_or_end();
					end
					PH_IDLECYC: begin
						lo = 1'b0;
						if (idle_cnt > 8'd0) idle_cnt--;
						if (idle_cnt == 8'd0) fin = 1'b1;
					end
					PH_RELEASE_END: begin
						drv = 1'b0;
						cnt--;
						if (cnt == 6'd0) fin = 1'b1;
					end
					PH_TRN_WZ: begin
						drv = 1'b0;
						cnt--;
						if (cnt == 6'd0) ph = PH_WZERO;
					end
					PH_WZERO: begin
						lo = 1'b0;
						cnt++;
						if (cnt >= 6'd33) fin = 1'b1;
					end
					default: begin
						ph = PH_IDLE;
						cnt = '0;
					end
				endcase
				if (fin) begin
					r.done_res = 1'b1;
					n_done++;
					if (ack_q == AckOk && req_q[1]) begin
						r.parity_error = par_q;
						r.read_data = shreg[31:0];
						n_read_ok++;
						if (par_q) n_perr++;
					end
					ph = PH_IDLE;
					cnt = '0;
				end
			end
			if (!drv) lo = 1'b0;
			r.line_out = lo;
			r.line_drive = drv;
			r.ack_code = ack_q;
			return r;
		endfunction

		function void note_input(swd_in_t it);
			n_items++;
			pending_results.push_back(advance_engine(it));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= MaxReports) begin
					$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				end
			end
		endfunction

		function void check_result(swd_out_t got);
			swd_out_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MaxReports) begin
					$display("%0t: result with none expected, expected nothing actual %h",
						$time, got);
				end
				return;
			end
			want = pending_results.pop_front();
			compare_field("line_out", want.line_out, got.line_out);
			compare_field("line_drive", want.line_drive, got.line_drive);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("ack_code", want.ack_code, got.ack_code);
			compare_field("parity_error", want.parity_error, got.parity_error);
			compare_field("read_data", want.read_data, got.read_data);
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	swd_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	swd_out_t out_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	swd_transfer_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	swd_host_transfer_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_input(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			out_ready <= 1'b0;
			hold_left <= HoldCycles;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high.
	task automatic drive_item(swd_in_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(logic [2:0] trn, logic [7:0] idle, logic dpw);
		write_cfg(CfgTurnaround, {5'($urandom_range(0, 31)), trn});
		write_cfg(CfgIdle, idle);
		write_cfg(CfgDataOnWait, {7'($urandom_range(0, 127)), dpw});
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic send_start(logic [3:0] req, logic [31:0] wd);
		swd_in_t it;
		it.cmd = 1'b0;
		it.request_bits = req;
		it.write_data = wd;
		it.line_sample = 1'($urandom_range(0, 1));
		drive_item(it);
	endtask

	task automatic send_idle_tick(logic ls);
		swd_in_t it;
		it.cmd = 1'b1;
		it.request_bits = 4'($urandom_range(0, 15));
		it.write_data = $urandom;
		it.line_sample = ls;
		drive_item(it);
	endtask

	// Ticks the engine until the transfer ends, answering the ack with the
	// given pattern and occasionally slipping in an ignored start.
	task automatic finish_transfer(logic [2:0] ack_plan, int noise_pct);
		swd_in_t it;
		while (sb.ph != PH_IDLE) begin
			it.cmd = ($urandom_range(0, 99) >= noise_pct);
			it.request_bits = 4'($urandom_range(0, 15));
			it.write_data = $urandom;
			if (sb.ph == PH_ACK) begin
				it.line_sample = ack_plan[sb.cnt[1:0]];
			end else begin
				it.line_sample = 1'($urandom_range(0, 1));
			end
			drive_item(it);
		end
	endtask

	task automatic random_transfer();
		logic [3:0]  req;
		logic [31:0] wd;
		logic [2:0]  ack_plan;
		int pick;
		if ($urandom_range(0, 99) < 8) send_idle_tick(1'($urandom_range(0, 1)));
		req = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 19);
		wd = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			ack_plan = AckOk;
		end else if (pick < 80) begin
			ack_plan = AckWait;
		end else if (pick < 88) begin
			ack_plan = AckFault;
		end else begin
			ack_plan = 3'($urandom_range(0, 7));
		end
		send_start(req, wd);
		finish_transfer(ack_plan, 4);
	endtask

	initial begin
		int p;
		int phase_start;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_tick(1'b0);
		send_idle_tick(1'b1);
		send_start(4'hF, 32'hFFFF_FFFF);
		send_start(4'h0, 32'h0);
		finish_transfer(AckWait, 0);
		send_start(4'h0, 32'h0);
		finish_transfer(AckFault, 0);
		wait_drained();

		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			case (p)
				1: configure(3'd4, 8'd1, 1'b1);
				2: configure(3'd0, 8'd0, 1'b0);
				3: configure(3'd7, 8'd255, 1'b1);
				4: configure(3'd2, 8'd3, 1'b0);
				5: configure(3'd5, 8'd0, 1'b1);
				6: configure(3'($urandom_range(0, 7)), 8'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)));
				7: configure(3'd3, 8'($urandom_range(0, 40)), 1'($urandom_range(0, 1)));
				default: ;
			endcase
			if (p == 4) hold_req = 1'b1;
			phase_start = sb.n_items;
			while (sb.n_items - phase_start < PhaseBudget) begin
				random_transfer();
				if (p == 2 && sb.n_items - phase_start >= PhaseBudget / 2
						&& sb.n_items - phase_start < PhaseBudget / 2 + 60) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		$display("Run covered %0d transactions and %0d completed transfers over 8 settings.",
			sb.n_items, sb.n_done);
		$display("Of these, %0d were OK reads, %0d of them with a data parity error.",
			sb.n_read_ok, sb.n_perr);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* swd_host_transfer_engine.f */
sv/swd_hte_pkg.sv
sv/swd_host_transfer_engine.sv
sv/swd_hte_checker.sv
test/swd_host_transfer_engine_tb.sv
